>>> hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants for the websocket frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  // header constants
  localparam logic [7:0] FIRST_BYTE_TEXT = 8'h81;  // fin + text opcode
  localparam int unsigned MASK_BIT_POS   = 7;
  localparam logic [6:0] LEN_EXT16       = 7'd126; // 16-bit length follows

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_FIRST   = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_EXT_HI  = 5'b00100,
    PH_EXT_LO  = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIRST = 2'd1,
    ST_MASKED    = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  // one result
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
    status_e    status;
  } res_t;

endpackage : wsd_pkg

`default_nettype wire

>>> hw/rtl/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_if
// valid/ready channels for frame bytes in and results out
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface : wsd_in_if

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       data_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, data, data_valid, last, status, input ready);
  modport sink   (input valid, data, data_valid, last, status, output ready);
endinterface : wsd_out_if

`default_nettype wire

>>> hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// header state machine and payload counter, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          frame_end_i,
  output wsd_pkg::res_t      res_o,
  output logic               has_res_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic        drop_q, drop_d;

  logic        len_load;
  logic [15:0] len_val;
  logic [15:0] cnt_inc;

  assign cnt_inc = cnt_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    has_res_o = 1'b0;
    res_o     = '0;
    len_load  = 1'b0;
    len_val   = '0;

    if (drop_q) begin
      if (frame_end_i) begin
        drop_d  = 1'b0;
        phase_d = PH_FIRST;
      end
    end else begin
      unique case (phase_q)
        PH_LEN: begin
          if (rx_byte_i[MASK_BIT_POS]) begin
            phase_d      = PH_FIRST;
            drop_d       = !frame_end_i;
            has_res_o    = 1'b1;
            res_o.last   = 1'b1;
            res_o.status = ST_MASKED;
          end else if (rx_byte_i[6:0] == LEN_EXT16) begin
            if (frame_end_i) begin
              phase_d      = PH_FIRST;
              has_res_o    = 1'b1;
              res_o.last   = 1'b1;
              res_o.status = ST_TRUNC;
            end else begin
              phase_d = PH_EXT_HI;
            end
          end else begin
            len_load = 1'b1;
            len_val  = {9'd0, rx_byte_i[6:0]};
          end
        end
        PH_EXT_HI: begin
          len_d = {rx_byte_i, 8'd0};
          if (frame_end_i) begin
            phase_d      = PH_FIRST;
            has_res_o    = 1'b1;
            res_o.last   = 1'b1;
            res_o.status = ST_TRUNC;
          end else begin
            phase_d = PH_EXT_LO;
          end
        end
        PH_EXT_LO: begin
          len_load = 1'b1;
          len_val  = len_q | {8'd0, rx_byte_i};
        end
        PH_PAYLOAD: begin
          cnt_d            = cnt_inc;
          has_res_o        = 1'b1;
          res_o.data       = rx_byte_i;
          res_o.data_valid = 1'b1;
          if (cnt_inc == len_q) begin
            phase_d    = PH_FIRST;
            drop_d     = !frame_end_i;
            res_o.last = 1'b1;
          end else if (frame_end_i) begin
            phase_d      = PH_FIRST;
            res_o.last   = 1'b1;
            res_o.status = ST_TRUNC;
          end
        end
        default: begin
          // expect first byte, also any stray phase code
          if (rx_byte_i != FIRST_BYTE_TEXT) begin
            phase_d      = PH_FIRST;
            drop_d       = !frame_end_i;
            has_res_o    = 1'b1;
            res_o.last   = 1'b1;
            res_o.status = ST_BAD_FIRST;
          end else if (frame_end_i) begin
            phase_d      = PH_FIRST;
            has_res_o    = 1'b1;
            res_o.last   = 1'b1;
            res_o.status = ST_TRUNC;
          end else begin
            phase_d = PH_LEN;
          end
        end
      endcase

      // length complete
      if (len_load) begin
        len_d = len_val;
        cnt_d = '0;
        if (len_val == 16'd0) begin
          phase_d    = PH_FIRST;
          drop_d     = !frame_end_i;
          has_res_o  = 1'b1;
          res_o.last = 1'b1;
        end else if (frame_end_i) begin
          phase_d      = PH_FIRST;
          has_res_o    = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = ST_TRUNC;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      len_q   <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
    end
  end

endmodule : wsd_parser

`default_nettype wire

>>> hw/rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// receive-side deframer for unmasked final text frames
// ----------------------------------------------------------------------------
// Takes the bytes of a received buffer one request per byte on in_i, with
// frame_end marking the buffer's last byte, and returns at most one result
// per byte on out_o. The header must be 0x81 then a length byte with the
// mask bit clear; length 126 pulls a 16-bit big-endian length from the next
// two bytes, 127 is taken as a plain length. Each payload byte comes out with
// data_valid set, the frame's last byte with last set. Errors (bad first
// byte, masked frame, buffer ending early) give one result with last set and
// the status code; after an error or a complete frame, bytes up to frame_end
// are dropped silently. One byte is taken every cycle unless a byte with a
// result waits on a full, stalled output register. A byte is held in the
// input register while the header state machine decides on it, and its
// result lands in the output register. The input register refills while
// the output register still holds a result; only a byte that makes a
// result waits on a full, stalled output register.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wsd_in_if.sink     in_i,
  wsd_out_if.source  out_o
);
  import wsd_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       end_q;

  // output register
  logic       out_vld_q;
  res_t       out_q;

  // parser handshake
  res_t       res;
  logic       has_res;
  logic       out_free;
  logic       step;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_q || out_o.ready;
  // a byte without a result never waits on the output side
  assign step     = in_vld_q && (out_free || !has_res);
  assign in_i.ready = !in_vld_q || step;

  wsd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_byte_i  (byte_q),
    .frame_end_i(end_q),
    .res_o      (res),
    .has_res_o  (has_res)
  );

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.rx_byte;
      end_q  <= in_i.frame_end;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && has_res) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (step && has_res) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.data       = out_q.data;
  assign out_o.data_valid = out_q.data_valid;
  assign out_o.last       = out_q.last;
  assign out_o.status     = out_q.status;

  // a result produced by the parser is always captured
  a_res_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_free && has_res) |=> out_vld_q)
    else $error("parser result lost");

  // with the output register empty, the input side never stalls
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input stalled with empty output");

  // payload results only carry ok or truncated status
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.data_valid) |-> (out_q.status == ST_OK ||
                                         out_q.status == ST_TRUNC))
    else $error("payload result with header error status");

  // any error or empty-frame result closes the frame
  a_nondata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.data_valid) |-> out_q.last)
    else $error("non-payload result without last");

endmodule : websocket_frame_deframer_top

`default_nettype wire
